[rtl/multi_channel_phase_cut_dimmer_top_macros.svh]
// Assertion macros for the phase-cut dimmer checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef MULTI_CHANNEL_PHASE_CUT_DIMMER_TOP_MACROS_SVH
`define MULTI_CHANNEL_PHASE_CUT_DIMMER_TOP_MACROS_SVH

// checked in the cycle after the antecedent, reset included
`define PCD_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pcd check failed");

// checked in the same cycle, outside reset
`define PCD_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcd check failed");

`endif

[rtl/pcd_pkg.sv]
// Shared types, constants and the delay function of the phase-cut dimmer.
// No dependencies.
`timescale 1ns / 1ps

package pcd_pkg;

    localparam int OUT_BITS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] LEVEL_FULL  = 8'd255;
    localparam logic [7:0] INTENT_OFF  = 8'd0;
    localparam logic [7:0] INTENT_FULL = 8'd255;

    localparam logic FUNC_COMPARE   = 1'b0;
    localparam logic FUNC_SET_LEVEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD = 2'd3;

    localparam logic [7:0]  MIN_LEVEL_RST    = 8'd10;
    localparam logic [7:0]  MAX_LEVEL_RST    = 8'd245;
    localparam logic [7:0]  RAMP_STEP_RST    = 8'd58;
    localparam logic [15:0] CYCLE_PERIOD_RST = 16'd14400;

    typedef struct packed {
        logic       func;
        logic [1:0] channel;
        logic [7:0] level;
        logic [7:0] on_intent;
        logic       start_ramp;
    } pcd_in_t;

    typedef struct packed {
        logic [15:0]         compare_value;
        logic [OUT_BITS-1:0] led_levels;
        logic [OUT_BITS-1:0] ramp_busy;
    } pcd_out_t;

    typedef struct packed {
        logic [7:0]  min_level;
        logic [7:0]  max_level;
        logic [7:0]  ramp_step;
        logic [15:0] cycle_period;
    } pcd_cfg_t;

    // switch-on delay in ticks: (255 - level) * step
    function automatic logic [15:0] pcd_delay(input logic [7:0] lvl, input logic [7:0] step);
        return {8'd0, LEVEL_FULL - lvl} * {8'd0, step};
    endfunction

endpackage

[rtl/pcd_cfg_regs.sv]
// Configuration registers of the phase-cut dimmer.
// Depends on pcd_pkg.
`timescale 1ns / 1ps

module pcd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output pcd_pkg::pcd_cfg_t                 cfg
);
    import pcd_pkg::*;

    pcd_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_level    <= MIN_LEVEL_RST;
            cfg_reg.max_level    <= MAX_LEVEL_RST;
            cfg_reg.ramp_step    <= RAMP_STEP_RST;
            cfg_reg.cycle_period <= CYCLE_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_LEVEL:    cfg_reg.min_level    <= cfg_wdata[7:0];
                CFG_MAX_LEVEL:    cfg_reg.max_level    <= cfg_wdata[7:0];
                CFG_RAMP_STEP:    cfg_reg.ramp_step    <= cfg_wdata[7:0];
                CFG_CYCLE_PERIOD: cfg_reg.cycle_period <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/pcd_sort.sv]
// Rank sort of the per-channel delays, ascending, ties kept in channel order.
// Depends on nothing.
`timescale 1ns / 1ps

module pcd_sort #(
    parameter int CHANNELS = 4
) (
    input  logic [CHANNELS-1:0][15:0] vals,
    output logic [CHANNELS-1:0][15:0] sorted
);
    localparam int RW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CHANNELS-1:0][RW-1:0] rank;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < CHANNELS; j++) begin
                if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            sorted[k] = '0;
            for (int i = 0; i < CHANNELS; i++) begin
                if (rank[i] == RW'(k)) begin
                    sorted[k] = sorted[k] | vals[i];
                end
            end
        end
    end

endmodule

[rtl/pcd_sched.sv]
// Scheduler state and single-pass update: set-level commands, cycle start
// with ramp step and re-sort, and slot matching. Depends on pcd_pkg, pcd_sort.
`timescale 1ns / 1ps

module pcd_sched #(
    parameter int CHANNELS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               proceed,
    input  pcd_pkg::pcd_in_t   item,
    input  pcd_pkg::pcd_cfg_t  cfg,
    output pcd_pkg::pcd_out_t  result
);
    import pcd_pkg::*;

    localparam int SW = $clog2(CHANNELS + 1);
    localparam int PW = (CHANNELS > OUT_BITS) ? CHANNELS : OUT_BITS;

    logic [CHANNELS-1:0][15:0] tgt_reg, tgt_next, rmp_reg, rmp_next, srt_reg, srt_next;
    logic [CHANNELS-1:0][7:0]  int_reg, int_next;
    logic [CHANNELS-1:0]       arm_reg, arm_next, pin_reg, pin_next;
    logic [SW-1:0]             slot_reg, slot_next;
    logic [15:0]               nc_reg, nc_next;

    logic [CHANNELS-1:0][15:0] tgt_tick, rmp_tick, srt_tick;
    logic [CHANNELS-1:0]       arm_tick, pin_tick;
    logic                      tick_any;

    logic [7:0]    lvl_clamp;
    logic [15:0]   set_dly, start_dly;
    logic [PW-1:0] pin_pad, arm_pad;

    // clamp; with inverted limits the low limit wins below it
    assign lvl_clamp = (item.level < cfg.min_level) ? cfg.min_level :
                       (item.level > cfg.max_level) ? cfg.max_level : item.level;
    assign set_dly   = pcd_delay(lvl_clamp, cfg.ramp_step);
    assign start_dly = pcd_delay(cfg.min_level, cfg.ramp_step);

    // cycle start: pins with a nonzero delay go low, one ramp step per armed channel
    always_comb begin
        logic [15:0] tg;
        logic [15:0] rd;
        logic [15:0] step16;
        tg       = '0;
        rd       = '0;
        step16   = {8'd0, cfg.ramp_step};
        tgt_tick = tgt_reg;
        rmp_tick = rmp_reg;
        arm_tick = arm_reg;
        tick_any = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            pin_tick[i] = (tgt_reg[i] != 16'd0) ? 1'b0 : pin_reg[i];
        end
        for (int i = 0; i < CHANNELS; i++) begin
            if (arm_reg[i]) begin
                tick_any = 1'b1;
                tg = tgt_reg[i];
                rd = rmp_reg[i];
                if (tg > rd) begin
                    rd = ((tg - rd) <= step16) ? tg : rd + step16;
                end else if (tg < rd) begin
                    rd = ((rd - tg) <= step16) ? tg : rd - step16;
                end
                rmp_tick[i] = rd;
                if (rd == tg) begin
                    arm_tick[i] = 1'b0;
                    if ((int_reg[i] == INTENT_OFF) || (int_reg[i] == INTENT_FULL)) begin
                        tgt_tick[i] = '0;
                        rmp_tick[i] = '0;
                        pin_tick[i] = (int_reg[i] == INTENT_FULL);
                    end
                end
            end
        end
    end

    pcd_sort #(
        .CHANNELS (CHANNELS)
    ) u_sort (
        .vals   (rmp_tick),
        .sorted (srt_tick)
    );

    always_comb begin
        logic [15:0] due;
        logic [SW-1:0] hits;
        logic [SW:0] sum;
        logic found;
        due       = '0;
        hits      = '0;
        sum       = '0;
        found     = 1'b0;
        tgt_next  = tgt_reg;
        rmp_next  = rmp_reg;
        srt_next  = srt_reg;
        int_next  = int_reg;
        arm_next  = arm_reg;
        pin_next  = pin_reg;
        slot_next = slot_reg;
        nc_next   = nc_reg;
        case (item.func)
            FUNC_SET_LEVEL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(item.channel) == i) begin
                        if ((rmp_reg[i] == 16'd0) && (int_reg[i] == INTENT_OFF)) begin
                            rmp_next[i] = start_dly;
                        end
                        tgt_next[i] = set_dly;
                        int_next[i] = item.on_intent;
                        if (item.start_ramp) begin
                            arm_next[i] = 1'b1;
                        end
                    end
                end
            end
            FUNC_COMPARE: begin
                if (slot_reg >= SW'(CHANNELS)) begin
                    tgt_next  = tgt_tick;
                    rmp_next  = rmp_tick;
                    arm_next  = arm_tick;
                    pin_next  = pin_tick;
                    srt_next  = tick_any ? srt_tick : srt_reg;
                    slot_next = SW'(CHANNELS);
                    nc_next   = cfg.cycle_period;
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (!found && (srt_next[k] != 16'd0)) begin
                            found     = 1'b1;
                            slot_next = SW'(k);
                            nc_next   = srt_next[k];
                        end
                    end
                end else begin
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (slot_reg == SW'(k)) begin
                            due = srt_reg[k];
                        end
                    end
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (rmp_reg[i] == due) begin
                            hits = hits + 1'b1;
                            if (tgt_reg[i] != 16'd0) begin
                                pin_next[i] = 1'b1;
                            end
                        end
                    end
                    sum = {1'b0, slot_reg} + {1'b0, hits};
                    if ((hits == '0) || (sum > (SW + 1)'(CHANNELS))) begin
                        slot_next = SW'(CHANNELS);
                    end else begin
                        slot_next = sum[SW-1:0];
                    end
                    nc_next = cfg.cycle_period;
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (slot_next == SW'(k)) begin
                            nc_next = srt_reg[k];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg  <= '0;
            rmp_reg  <= '0;
            srt_reg  <= '0;
            int_reg  <= '0;
            arm_reg  <= '0;
            pin_reg  <= '0;
            slot_reg <= SW'(CHANNELS);
            nc_reg   <= CYCLE_PERIOD_RST;
        end else if (proceed) begin
            tgt_reg  <= tgt_next;
            rmp_reg  <= rmp_next;
            srt_reg  <= srt_next;
            int_reg  <= int_next;
            arm_reg  <= arm_next;
            pin_reg  <= pin_next;
            slot_reg <= slot_next;
            nc_reg   <= nc_next;
        end
    end

    assign pin_pad = PW'(pin_next);
    assign arm_pad = PW'(arm_next);

    assign result.compare_value = nc_next;
    assign result.led_levels    = pin_pad[OUT_BITS-1:0];
    assign result.ramp_busy     = arm_pad[OUT_BITS-1:0];

endmodule

[rtl/multi_channel_phase_cut_dimmer_top.sv]
// Top level of the multi-channel phase-cut dimmer scheduler.
// Depends on pcd_pkg, pcd_cfg_regs, pcd_sched.
//
// Usage: each s_ beat is either a timer compare event (func 0) or a
// set-level command (func 1) for one channel. Every beat gives exactly one
// m_ beat: the next compare value, the pin level of each channel and the
// per-channel ramp-busy flags, all as they stand after that beat.
// Throughput: one beat per cycle while the receiver does not stall; the
// input register feeds a single combinational update pass (ramp step,
// CHANNELS-way rank sort and slot match) that lands in the result register.
// When the receiver stalls, the result register holds its beat and one
// more input beat is taken into the input register; s_ready then drops
// until m_ready returns. Configuration is written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write it only while idle, as
// the block itself does not enforce this.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// all delays, pins and ramps, and puts the slot at cycle start.
`timescale 1ns / 1ps

module multi_channel_phase_cut_dimmer_top #(
    parameter int CHANNELS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pcd_pkg::pcd_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pcd_pkg::pcd_out_t               m_data,
    input  logic                            cfg_wr_en,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pcd_pkg::*;

    pcd_cfg_t cfg;
    pcd_in_t  in_data_reg;
    logic     in_valid_reg;
    pcd_out_t result;
    pcd_out_t out_data_reg;
    logic     out_valid_reg;
    logic     proceed;

    assign proceed = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;

    pcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcd_sched #(
        .CHANNELS (CHANNELS)
    ) u_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proceed (proceed),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proceed) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proceed) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[rtl/pcd_checker.sv]
// Port-level checker for the phase-cut dimmer top, bound to every instance.
// Depends on pcd_pkg and multi_channel_phase_cut_dimmer_top_macros.svh.
`timescale 1ns / 1ps
`include "multi_channel_phase_cut_dimmer_top_macros.svh"

module pcd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input pcd_pkg::pcd_in_t   s_data,
    input logic               m_valid,
    input logic               m_ready,
    input pcd_pkg::pcd_out_t  m_data
);
    import pcd_pkg::*;

    logic in_beat;
    assign in_beat = s_valid && s_ready;

    `PCD_CHECK_NEXT(a_reset_idle, !aresetn, !m_valid && s_ready)
    `PCD_CHECK_NEXT(a_stall_hold, aresetn && m_valid && !m_ready, m_valid && $stable(m_data))
    `PCD_CHECK_NEXT(a_no_phantom, aresetn && !m_valid && !in_beat ##1 !m_valid, !m_valid)
    `PCD_CHECK_NOW(a_ready_on_drain, m_ready, s_ready)

endmodule

bind multi_channel_phase_cut_dimmer_top pcd_checker u_pcd_checker (.*);
